// ===== hw/rtl/scancode_line_editor_assert.svh =====
// Assertion macros for the scancode line editor.
// Every macro samples on clk and is disabled while rst is high.
`ifndef SCANCODE_LINE_EDITOR_ASSERT_SVH
`define SCANCODE_LINE_EDITOR_ASSERT_SVH

// Condition must hold at every sampled edge
`define SLE_ASSERT_ALWAYS(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("sle assertion failed");

// Same-cycle implication
`define SLE_ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sle assertion failed");

// Next-cycle implication
`define SLE_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sle assertion failed");

`endif

// ===== hw/rtl/sle_pkg.sv =====
// Shared types, constants and key tables for the scancode line editor.
// Used by the controller, the datapath and the top level.
package sle_pkg;

  // Sizing
  localparam int LINE_BYTES    = 256;
  localparam int HISTORY_DEPTH = 32;

  localparam int LINE_AW = $clog2(LINE_BYTES);
  localparam int HIST_CW = $clog2(HISTORY_DEPTH + 1);
  localparam int HIST_SW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int HIST_WORDS = HISTORY_DEPTH * LINE_BYTES;
  localparam int HIST_AW = $clog2(HIST_WORDS);

  // Field widths
  localparam int SC_W  = 8;
  localparam int CH_W  = 7;
  localparam int LEN_W = 8;
  localparam int BYTE_W = 8;

  // Opcodes
  localparam logic OP_KEY  = 1'b0;
  localparam logic OP_READ = 1'b1;

  // Result events
  typedef enum logic [2:0] {
    EV_NONE    = 3'd0,
    EV_ECHO    = 3'd1,
    EV_ERASE   = 3'd2,
    EV_SUBMIT  = 3'd3,
    EV_CANCEL  = 3'd4,
    EV_REPLACE = 3'd5,
    EV_CLEAR   = 3'd6
  } event_t;

  // Set-1 scancodes
  localparam logic [SC_W-1:0] SC_LSHIFT = 8'h2A;
  localparam logic [SC_W-1:0] SC_RSHIFT = 8'h36;
  localparam logic [SC_W-1:0] SC_CTRL   = 8'h1D;
  localparam logic [SC_W-1:0] SC_UP     = 8'h48;
  localparam logic [SC_W-1:0] SC_DOWN   = 8'h50;
  localparam logic [SC_W-1:0] SC_KEY_C  = 8'h2E;
  localparam logic [SC_W-1:0] SC_KEY_L  = 8'h26;
  localparam int SC_BREAK_BIT = 7;

  // ASCII control characters
  localparam logic [CH_W-1:0] CH_NUL = 7'h00;
  localparam logic [CH_W-1:0] CH_BS  = 7'h08;
  localparam logic [CH_W-1:0] CH_TAB = 7'h09;
  localparam logic [CH_W-1:0] CH_LF  = 7'h0A;

  // US key tables, padded to a power of two with empty entries
  localparam int KEY_TABLE_LEN   = 58;
  localparam int KEY_TABLE_SLOTS = 64;

  localparam logic [CH_W-1:0] KEYMAP_PLAIN [KEY_TABLE_SLOTS] = '{
    7'h00, 7'h00, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37, 7'h38,
    7'h39, 7'h30, 7'h2D, 7'h3D, 7'h08, 7'h09, 7'h71, 7'h77, 7'h65, 7'h72,
    7'h74, 7'h79, 7'h75, 7'h69, 7'h6F, 7'h70, 7'h5B, 7'h5D, 7'h0A, 7'h00,
    7'h61, 7'h73, 7'h64, 7'h66, 7'h67, 7'h68, 7'h6A, 7'h6B, 7'h6C, 7'h3B,
    7'h27, 7'h60, 7'h00, 7'h5C, 7'h7A, 7'h78, 7'h63, 7'h76, 7'h62, 7'h6E,
    7'h6D, 7'h2C, 7'h2E, 7'h2F, 7'h00, 7'h2A, 7'h00, 7'h20, 7'h00, 7'h00,
    7'h00, 7'h00, 7'h00, 7'h00
  };

  localparam logic [CH_W-1:0] KEYMAP_SHIFTED [KEY_TABLE_SLOTS] = '{
    7'h00, 7'h00, 7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5E, 7'h26, 7'h2A,
    7'h28, 7'h29, 7'h5F, 7'h2B, 7'h08, 7'h09, 7'h51, 7'h57, 7'h45, 7'h52,
    7'h54, 7'h59, 7'h55, 7'h49, 7'h4F, 7'h50, 7'h7B, 7'h7D, 7'h0A, 7'h00,
    7'h41, 7'h53, 7'h44, 7'h46, 7'h47, 7'h48, 7'h4A, 7'h4B, 7'h4C, 7'h3A,
    7'h22, 7'h7E, 7'h00, 7'h7C, 7'h5A, 7'h58, 7'h43, 7'h56, 7'h42, 7'h4E,
    7'h4D, 7'h3C, 7'h3E, 7'h3F, 7'h00, 7'h2A, 7'h00, 7'h20, 7'h00, 7'h00,
    7'h00, 7'h00, 7'h00, 7'h00
  };

  function automatic logic [CH_W-1:0] key_ascii(input logic [5:0] code,
                                                input logic shifted);
    return shifted ? KEYMAP_SHIFTED[code] : KEYMAP_PLAIN[code];
  endfunction

  // Controller to datapath
  typedef struct packed {
    logic accept;    // input item taken this cycle
    logic exec;      // decode and update state
    logic copy;      // line/history copy in progress
    logic load_out;  // move result into output register
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic start_copy;  // item needs a copy pass
    logic copy_done;   // copy pass finished
  } status_t;

endpackage

// ===== hw/rtl/scancode_line_editor.sv =====
// Scancode line editor: PS/2 set-1 keys in, line editing events out.
// Input channel: in_valid/in_stall with opcode, scancode, read_index. An item
//   is either a key scancode (opcode 0) or a read of one line byte (opcode 1).
// Output channel: out_valid/out_stall with event_res, char_code, line_length,
//   read_data; exactly one result item per input item, in order.
// Timing: an item is decoded in the cycle after it is taken, and its result is
//   then moved into the output register; the next item is taken only once the
//   controller is back in idle.
// A history recall or a submit that stores a line runs a copy between the
//   line RAM and the history RAM, one byte per cycle with registered reads;
//   the result is loaded and the next item taken only after the copy is done.
// The output register parts the two channels: a new item is taken while a
//   result still waits. If the receiver stalls, the next result is held in
//   the datapath and the input stalls until the output register frees up.
// Reset (rst, synchronous) clears the shift and ctrl flags, the line length,
//   the history count and cursor, and the valid flag. The RAM contents are not
//   cleared; no read can reach a byte that was never written.
// Depends on sle_pkg, sle_ctrl, sle_dp, sle_ram and the assertion header.
`include "scancode_line_editor_assert.svh"

module scancode_line_editor (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          opcode,
  input  logic [sle_pkg::SC_W-1:0]      scancode,
  input  logic [sle_pkg::SC_W-1:0]      read_index,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [2:0]                    event_res,
  output logic [sle_pkg::CH_W-1:0]      char_code,
  output logic [sle_pkg::LEN_W-1:0]     line_length,
  output logic [sle_pkg::BYTE_W-1:0]    read_data
);

  sle_pkg::cmd_t    cmd;
  sle_pkg::status_t status;

  sle_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  sle_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .opcode      (opcode),
    .scancode    (scancode),
    .read_index  (read_index),
    .event_res   (event_res),
    .char_code   (char_code),
    .line_length (line_length),
    .read_data   (read_data)
  );

  // Checks
  `SLE_ASSERT_ALWAYS(a_cmd_onehot, $onehot0({cmd.accept, cmd.exec, cmd.copy, cmd.load_out}))
  `SLE_ASSERT_IMPLY(a_idle_no_work, !in_stall, !(cmd.exec || cmd.copy || cmd.load_out))
  `SLE_ASSERT_NEXT(a_accept_exec, cmd.accept, cmd.exec && in_stall)
  `SLE_ASSERT_NEXT(a_load_valid, cmd.load_out, out_valid)

endmodule

// ===== hw/rtl/sle_ram.sv =====
// Generic simple dual-port RAM with registered read.
// No package dependencies.
module sle_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic                                      re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hw/rtl/sle_ctrl.sv =====
// Sequencing controller for the scancode line editor.
// Depends on sle_pkg for the command and status structs.
module sle_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  output logic             out_valid,
  input  logic             out_stall,
  input  sle_pkg::status_t status,
  output sle_pkg::cmd_t    cmd
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_EXEC = 4'b0010,
    ST_COPY = 4'b0100,
    ST_DONE = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_valid_next;

  assign in_stall = (state != ST_IDLE);

  // Commands
  always_comb begin
    cmd.accept   = (state == ST_IDLE) && in_valid;
    cmd.exec     = (state == ST_EXEC);
    cmd.copy     = (state == ST_COPY);
    cmd.load_out = (state == ST_DONE) && (!out_valid || !out_stall);
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_EXEC;
      end
      ST_EXEC: begin
        state_next = status.start_copy ? ST_COPY : ST_DONE;
      end
      ST_COPY: begin
        if (status.copy_done) state_next = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid || !out_stall) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Output valid holds until taken
  always_comb begin
    if (cmd.load_out) begin
      out_valid_next = 1'b1;
    end else begin
      out_valid_next = out_valid && out_stall;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

// ===== hw/rtl/sle_dp.sv =====
// Datapath of the scancode line editor: key decode, line and history stores,
// copy engine and result registers. Depends on sle_pkg and sle_ram.
module sle_dp (
  input  logic                          clk,
  input  logic                          rst,
  input  sle_pkg::cmd_t                 cmd,
  output sle_pkg::status_t              status,
  input  logic                          opcode,
  input  logic [sle_pkg::SC_W-1:0]      scancode,
  input  logic [sle_pkg::SC_W-1:0]      read_index,
  output logic [2:0]                    event_res,
  output logic [sle_pkg::CH_W-1:0]      char_code,
  output logic [sle_pkg::LEN_W-1:0]     line_length,
  output logic [sle_pkg::BYTE_W-1:0]    read_data
);

  // Latched item
  logic                          op_r;
  logic [sle_pkg::SC_W-1:0]      sc_r;
  logic [sle_pkg::SC_W-1:0]      idx_r;

  // Editor state
  logic                          shift_held, shift_next;
  logic                          ctrl_held, ctrl_next;
  logic [sle_pkg::LINE_AW-1:0]   line_count, line_count_next;
  logic                          submitted, submitted_next;
  logic [sle_pkg::HIST_CW-1:0]   hist_used, hist_used_next;
  logic [sle_pkg::HIST_CW-1:0]   hist_cursor, hist_cursor_next;
  logic [sle_pkg::LINE_AW-1:0]   hist_len [sle_pkg::HISTORY_DEPTH];

  // Result of the current item
  sle_pkg::event_t               res_ev, res_ev_next;
  logic [sle_pkg::CH_W-1:0]      res_ch, res_ch_next;
  logic [sle_pkg::LEN_W-1:0]     res_len;
  logic [sle_pkg::BYTE_W-1:0]    res_rd, res_rd_next;

  // Copy engine
  logic                          cp_to_hist, cp_to_hist_next;
  logic [sle_pkg::LINE_AW-1:0]   cp_len, cp_len_next;
  logic [sle_pkg::HIST_SW-1:0]   cp_slot, cp_slot_next;
  logic [sle_pkg::LINE_AW-1:0]   cp_cnt;
  logic                          cp_wv;
  logic [sle_pkg::LINE_AW-1:0]   cp_wa;
  logic                          cp_rd_go;
  logic [sle_pkg::HIST_AW-1:0]   hist_base;

  // Decode helpers
  logic [sle_pkg::LINE_AW-1:0]   lc_eff;
  logic [sle_pkg::CH_W-1:0]      key_c;
  logic [sle_pkg::SC_W-1:0]      rel_code;
  logic [sle_pkg::HIST_CW-1:0]   recall_slot;
  logic [sle_pkg::LINE_AW-1:0]   recall_len;
  logic                          append;
  logic                          start_copy;
  logic                          hlen_we;

  // Memory ports
  logic                          line_we, line_re;
  logic [sle_pkg::LINE_AW-1:0]   line_waddr, line_raddr;
  logic [sle_pkg::BYTE_W-1:0]    line_wdata, line_rdata;
  logic                          hist_we, hist_re;
  logic [sle_pkg::HIST_AW-1:0]   hist_waddr, hist_raddr;
  logic [sle_pkg::BYTE_W-1:0]    hist_rdata;

  assign lc_eff   = submitted ? '0 : line_count;
  assign key_c    = sle_pkg::key_ascii(sc_r[5:0], shift_held);
  assign rel_code = {1'b0, sc_r[sle_pkg::SC_W-2:0]};

  // Key and read decode and state update
  always_comb begin
    shift_next       = shift_held;
    ctrl_next        = ctrl_held;
    line_count_next  = line_count;
    submitted_next   = submitted;
    hist_used_next   = hist_used;
    hist_cursor_next = hist_cursor;
    res_ev_next      = sle_pkg::EV_NONE;
    res_ch_next      = '0;
    res_rd_next      = '0;
    append           = 1'b0;
    start_copy       = 1'b0;
    hlen_we          = 1'b0;
    cp_to_hist_next  = 1'b0;
    cp_len_next      = lc_eff;
    cp_slot_next     = hist_used[sle_pkg::HIST_SW-1:0];
    recall_slot      = '0;
    recall_len       = '0;

    if (op_r == sle_pkg::OP_READ) begin
      if (idx_r < sle_pkg::SC_W'(line_count)) res_rd_next = line_rdata;
    end else begin
      // A submitted line is dropped by the next key
      submitted_next  = 1'b0;
      line_count_next = lc_eff;

      if (sc_r[sle_pkg::SC_BREAK_BIT]) begin
        if (rel_code == sle_pkg::SC_LSHIFT || rel_code == sle_pkg::SC_RSHIFT) begin
          shift_next = 1'b0;
        end else if (rel_code == sle_pkg::SC_CTRL) begin
          ctrl_next = 1'b0;
        end
      end else if (sc_r == sle_pkg::SC_LSHIFT || sc_r == sle_pkg::SC_RSHIFT) begin
        shift_next = 1'b1;
      end else if (sc_r == sle_pkg::SC_CTRL) begin
        ctrl_next = 1'b1;
      end else if (sc_r == sle_pkg::SC_UP) begin
        // Recall the next older entry
        if (hist_cursor < hist_used) begin
          hist_cursor_next = hist_cursor + 1'b1;
          recall_slot      = hist_used - hist_cursor_next;
          recall_len       = hist_len[recall_slot[sle_pkg::HIST_SW-1:0]];
          if (recall_len > sle_pkg::LINE_AW'(sle_pkg::LINE_BYTES - 1)) begin
            recall_len = sle_pkg::LINE_AW'(sle_pkg::LINE_BYTES - 1);
          end
          start_copy      = 1'b1;
          cp_len_next     = recall_len;
          cp_slot_next    = recall_slot[sle_pkg::HIST_SW-1:0];
          line_count_next = recall_len;
          res_ev_next     = sle_pkg::EV_REPLACE;
        end
      end else if (sc_r == sle_pkg::SC_DOWN) begin
        // Step toward the newest entry, then to an empty line
        if (hist_cursor != '0) begin
          hist_cursor_next = hist_cursor - 1'b1;
          res_ev_next      = sle_pkg::EV_REPLACE;
          if (hist_cursor_next == '0) begin
            line_count_next = '0;
          end else begin
            recall_slot = hist_used - hist_cursor_next;
            recall_len  = hist_len[recall_slot[sle_pkg::HIST_SW-1:0]];
            if (recall_len > sle_pkg::LINE_AW'(sle_pkg::LINE_BYTES - 1)) begin
              recall_len = sle_pkg::LINE_AW'(sle_pkg::LINE_BYTES - 1);
            end
            start_copy      = 1'b1;
            cp_len_next     = recall_len;
            cp_slot_next    = recall_slot[sle_pkg::HIST_SW-1:0];
            line_count_next = recall_len;
          end
        end
      end else if (ctrl_held && sc_r == sle_pkg::SC_KEY_C) begin
        line_count_next = '0;
        res_ev_next     = sle_pkg::EV_CANCEL;
      end else if (ctrl_held && sc_r == sle_pkg::SC_KEY_L) begin
        res_ev_next = sle_pkg::EV_CLEAR;
      end else if (sc_r < sle_pkg::SC_W'(sle_pkg::KEY_TABLE_LEN)) begin
        case (key_c)
          sle_pkg::CH_NUL, sle_pkg::CH_TAB: begin
            res_ev_next = sle_pkg::EV_NONE;
          end
          sle_pkg::CH_LF: begin
            // Submit; store non-empty lines while history has room
            if (lc_eff != '0 &&
                hist_used < sle_pkg::HIST_CW'(sle_pkg::HISTORY_DEPTH)) begin
              start_copy      = 1'b1;
              cp_to_hist_next = 1'b1;
              hlen_we         = 1'b1;
              hist_used_next  = hist_used + 1'b1;
            end
            hist_cursor_next = '0;
            submitted_next   = 1'b1;
            res_ev_next      = sle_pkg::EV_SUBMIT;
          end
          sle_pkg::CH_BS: begin
            if (lc_eff != '0) begin
              line_count_next = lc_eff - 1'b1;
              res_ev_next     = sle_pkg::EV_ERASE;
            end
          end
          default: begin
            if (lc_eff < sle_pkg::LINE_AW'(sle_pkg::LINE_BYTES - 1)) begin
              append          = 1'b1;
              line_count_next = lc_eff + 1'b1;
              res_ch_next     = key_c;
              res_ev_next     = sle_pkg::EV_ECHO;
            end
          end
        endcase
      end
    end
  end

  // Input latch
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_r  <= opcode;
      sc_r  <= scancode;
      idx_r <= read_index;
    end
  end

  // Editor control state
  always_ff @(posedge clk) begin
    if (rst) begin
      shift_held  <= 1'b0;
      ctrl_held   <= 1'b0;
      line_count  <= '0;
      submitted   <= 1'b0;
      hist_used   <= '0;
      hist_cursor <= '0;
    end else if (cmd.exec) begin
      shift_held  <= shift_next;
      ctrl_held   <= ctrl_next;
      line_count  <= line_count_next;
      submitted   <= submitted_next;
      hist_used   <= hist_used_next;
      hist_cursor <= hist_cursor_next;
    end
  end

  // Result, history lengths and copy setup
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      res_ev  <= res_ev_next;
      res_ch  <= res_ch_next;
      res_len <= sle_pkg::LEN_W'(line_count_next);
      res_rd  <= res_rd_next;
      if (hlen_we) hist_len[hist_used[sle_pkg::HIST_SW-1:0]] <= lc_eff;
      if (start_copy) begin
        cp_to_hist <= cp_to_hist_next;
        cp_len     <= cp_len_next;
        cp_slot    <= cp_slot_next;
      end
    end
  end

  // Copy engine: read at cp_cnt, write at cp_wa in the following cycle
  assign cp_rd_go  = cmd.copy && (cp_cnt < cp_len);
  assign hist_base = sle_pkg::HIST_AW'(cp_slot) * sle_pkg::HIST_AW'(sle_pkg::LINE_BYTES);
  assign status.start_copy = start_copy;
  assign status.copy_done  = !(cp_cnt < cp_len) && !cp_wv;

  always_ff @(posedge clk) begin
    if (rst) begin
      cp_wv <= 1'b0;
    end else if (cmd.exec) begin
      cp_wv <= 1'b0;
    end else begin
      cp_wv <= cp_rd_go;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      cp_cnt <= '0;
    end else if (cp_rd_go) begin
      cp_cnt <= cp_cnt + 1'b1;
    end
    cp_wa <= cp_cnt;
  end

  // Line store ports
  assign line_we    = (cmd.exec && append) || (cmd.copy && cp_wv && !cp_to_hist);
  assign line_waddr = cmd.exec ? lc_eff : cp_wa;
  assign line_wdata = cmd.exec ? {1'b0, key_c} : hist_rdata;
  assign line_re    = cmd.accept || (cp_rd_go && cp_to_hist);
  assign line_raddr = cmd.accept ? read_index[sle_pkg::LINE_AW-1:0] : cp_cnt;

  // History store ports
  assign hist_we    = cmd.copy && cp_wv && cp_to_hist;
  assign hist_waddr = hist_base + sle_pkg::HIST_AW'(cp_wa);
  assign hist_re    = cp_rd_go && !cp_to_hist;
  assign hist_raddr = hist_base + sle_pkg::HIST_AW'(cp_cnt);

  sle_ram #(
    .WIDTH (sle_pkg::BYTE_W),
    .DEPTH (sle_pkg::LINE_BYTES)
  ) u_line_ram (
    .clk   (clk),
    .we    (line_we),
    .waddr (line_waddr),
    .wdata (line_wdata),
    .re    (line_re),
    .raddr (line_raddr),
    .rdata (line_rdata)
  );

  sle_ram #(
    .WIDTH (sle_pkg::BYTE_W),
    .DEPTH (sle_pkg::HIST_WORDS)
  ) u_hist_ram (
    .clk   (clk),
    .we    (hist_we),
    .waddr (hist_waddr),
    .wdata (line_rdata),
    .re    (hist_re),
    .raddr (hist_raddr),
    .rdata (hist_rdata)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      event_res   <= res_ev;
      char_code   <= res_ch;
      line_length <= res_len;
      read_data   <= res_rd;
    end
  end

endmodule
